// ===== rtl/mae_pkg.sv =====
// ============================================================================
// Arithmetic executor package
// Shared constants, opcode names and the control/status structs that join
// the controller and the datapath.
// ============================================================================
package mae_pkg;

    localparam int DATA_W = 32;
    localparam int IDX_W = 5;
    localparam int OP_W = 4;
    localparam int REG_COUNT_DEFAULT = 32;
    localparam logic [DATA_W-1:0] TEXT_BASE_RESET = 32'h0040_0000;

    // Radix-2 divider: one quotient bit per cycle.
    localparam int DIV_STEPS = DATA_W;

    // Opcodes.
    localparam logic [OP_W-1:0] OP_ADD = 4'd0;
    localparam logic [OP_W-1:0] OP_SUB = 4'd1;
    localparam logic [OP_W-1:0] OP_MUL = 4'd2;
    localparam logic [OP_W-1:0] OP_DIV3 = 4'd3;
    localparam logic [OP_W-1:0] OP_ADDI = 4'd4;
    localparam logic [OP_W-1:0] OP_SUBI = 4'd5;
    localparam logic [OP_W-1:0] OP_MULT = 4'd6;
    localparam logic [OP_W-1:0] OP_DIV2 = 4'd7;
    localparam logic [OP_W-1:0] OP_MOVE = 4'd8;
    localparam logic [OP_W-1:0] OP_MFLO = 4'd9;
    localparam logic [OP_W-1:0] OP_MFHI = 4'd10;
    localparam logic [OP_W-1:0] OP_LI = 4'd11;

    // Register file read select.
    localparam logic [1:0] RSEL_A = 2'd0;
    localparam logic [1:0] RSEL_B = 2'd1;
    localparam logic [1:0] RSEL_D = 2'd2;

    typedef struct packed {
        logic       load;
        logic [1:0] rd_sel;
        logic       cap_a;
        logic       cap_b;
        logic       cap_d;
        logic       start;
        logic       div_step;
        logic       commit;
    } mae_cmd_t;

    typedef struct packed {
        logic is_div;
        logic out_free;
    } mae_status_t;

endpackage

// ===== rtl/mae_ram.sv =====
// ============================================================================
// Generic RAM
// One write port and one read port with registered read data.
// ============================================================================
module mae_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/mae_ctrl.sv =====
// ============================================================================
// Arithmetic executor controller
// Sequences operand reads, the execute step, the divider iterations and the
// final commit of one request at a time.
// ============================================================================
module mae_ctrl
    import mae_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  mae_status_t status,
    output mae_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RDA = 3'd1;
    localparam logic [2:0] S_RDB = 3'd2;
    localparam logic [2:0] S_RDD = 3'd3;
    localparam logic [2:0] S_CAPD = 3'd4;
    localparam logic [2:0] S_EXEC = 3'd5;
    localparam logic [2:0] S_DIV = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    localparam int STEP_W = $clog2(DIV_STEPS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next = step_reg;
        cmd = '0;
        cmd.rd_sel = RSEL_A;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_RDA;
                end
            end
            S_RDA:
            begin
                cmd.rd_sel = RSEL_A;
                state_next = S_RDB;
            end
            S_RDB:
            begin
                cmd.rd_sel = RSEL_B;
                cmd.cap_a = 1'b1;
                state_next = S_RDD;
            end
            S_RDD:
            begin
                cmd.rd_sel = RSEL_D;
                cmd.cap_b = 1'b1;
                state_next = S_CAPD;
            end
            S_CAPD:
            begin
                cmd.cap_d = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.start = 1'b1;
                step_next = '0;
                state_next = status.is_div ? S_DIV : S_DONE;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

    // A request is taken only while the controller is idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == S_RDA))
        else $error("load did not start the operand reads");

    // The divider runs its full count before the result is committed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && step_reg != STEP_LAST) |=> (state_reg == S_DIV))
        else $error("divider left early");

    // Commit returns the controller to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> !in_stall)
        else $error("controller not idle after commit");

endmodule

// ===== rtl/mae_datapath.sv =====
// ============================================================================
// Arithmetic executor datapath
// Register file, HI/LO, instruction counter, operand registers, multiplier,
// iterative divider and the output register.
// ============================================================================
module mae_datapath
    import mae_pkg::*;
#(
    parameter int REG_COUNT = REG_COUNT_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mae_cmd_t            cmd,
    output mae_status_t         status,
    input  logic                cfg_write,
    input  logic [DATA_W-1:0]   cfg_data,
    input  logic [OP_W-1:0]     opcode,
    input  logic [IDX_W-1:0]    dest_index,
    input  logic [IDX_W-1:0]    src_a_index,
    input  logic [IDX_W-1:0]    src_b_index,
    input  logic signed [DATA_W-1:0] immediate,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                write_enable,
    output logic [IDX_W-1:0]    write_index,
    output logic [DATA_W-1:0]   write_value,
    output logic [DATA_W-1:0]   hi_value,
    output logic [DATA_W-1:0]   lo_value,
    output logic [DATA_W-1:0]   next_address
);

    localparam int ADDR_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam logic [IDX_W:0] REG_LIMIT = (IDX_W + 1)'(REG_COUNT);

    // Instruction registers.
    logic [OP_W-1:0]   op_reg;
    logic [IDX_W-1:0]  rd_reg;
    logic [IDX_W-1:0]  ra_reg;
    logic [IDX_W-1:0]  rb_reg;
    logic [DATA_W-1:0] imm_reg;

    // Operands.
    logic [DATA_W-1:0] va_reg;
    logic [DATA_W-1:0] vb_reg;
    logic [DATA_W-1:0] vd_reg;

    // Architectural state.
    logic [REG_COUNT-1:0] written_reg;
    logic [DATA_W-1:0]    hi_reg;
    logic [DATA_W-1:0]    lo_reg;
    logic [DATA_W-1:0]    count_reg;
    logic [DATA_W-1:0]    text_base_reg;

    // Multiplier and divider.
    logic [2*DATA_W-1:0] prod_reg;
    logic [DATA_W-1:0]   rem_reg;
    logic [DATA_W-1:0]   quo_reg;
    logic [DATA_W-1:0]   divisor_reg;

    // Output register.
    logic              out_valid_reg;
    logic              out_we_reg;
    logic [IDX_W-1:0]  out_idx_reg;
    logic [DATA_W-1:0] out_val_reg;
    logic [DATA_W-1:0] out_hi_reg;
    logic [DATA_W-1:0] out_lo_reg;
    logic [DATA_W-1:0] out_addr_reg;

    // Register file read path.
    logic [IDX_W-1:0]  rd_idx;
    logic              rd_ok_reg;
    logic [DATA_W-1:0] ram_q;
    logic [DATA_W-1:0] rd_data;

    always_comb
    begin
        case (cmd.rd_sel)
            RSEL_A:  rd_idx = ra_reg;
            RSEL_B:  rd_idx = rb_reg;
            RSEL_D:  rd_idx = rd_reg;
            default: rd_idx = ra_reg;
        endcase
    end

    // Entries never written and indexes past the file read as zero.
    assign rd_data = rd_ok_reg ? ram_q : '0;

    // Divider step.
    logic [DATA_W:0] div_shift;
    logic            div_ge;
    logic [DATA_W:0] div_diff;

    assign div_shift = {rem_reg, quo_reg[DATA_W-1]};
    assign div_ge = (div_shift >= {1'b0, divisor_reg});
    assign div_diff = div_shift - {1'b0, divisor_reg};

    // Commit values.
    logic              is_valid_op;
    logic              wants_write;
    logic              do_write;
    logic [DATA_W-1:0] res_val;
    logic [DATA_W-1:0] hi_next;
    logic [DATA_W-1:0] lo_next;
    logic [DATA_W-1:0] count_next;
    logic [DATA_W-1:0] addr_next;
    logic              out_free;

    always_comb
    begin
        is_valid_op = 1'b1;
        wants_write = 1'b1;
        res_val = '0;
        hi_next = hi_reg;
        lo_next = lo_reg;
        case (op_reg)
            OP_ADD:  res_val = va_reg + vb_reg;
            OP_SUB:  res_val = va_reg - vb_reg;
            OP_MUL:  res_val = prod_reg[DATA_W-1:0];
            OP_DIV3: res_val = quo_reg;
            OP_ADDI: res_val = va_reg + imm_reg;
            OP_SUBI: res_val = va_reg - imm_reg;
            OP_MULT:
            begin
                wants_write = 1'b0;
                lo_next = prod_reg[DATA_W-1:0];
                hi_next = prod_reg[2*DATA_W-1:DATA_W];
            end
            OP_DIV2:
            begin
                wants_write = 1'b0;
                lo_next = quo_reg;
                hi_next = rem_reg;
            end
            OP_MOVE: res_val = va_reg;
            OP_MFLO: res_val = lo_reg;
            OP_MFHI: res_val = hi_reg;
            OP_LI:   res_val = imm_reg;
            default:
            begin
                is_valid_op = 1'b0;
                wants_write = 1'b0;
            end
        endcase
        do_write = wants_write && ({1'b0, rd_reg} < REG_LIMIT);
        count_next = count_reg + DATA_W'(is_valid_op);
        addr_next = text_base_reg + {count_next[DATA_W-3:0], 2'b00};
    end

    assign out_free = !out_valid_reg || !out_stall;

    assign status.is_div = (op_reg == OP_DIV3) || (op_reg == OP_DIV2);
    assign status.out_free = out_free;

    mae_ram #(
        .WIDTH (DATA_W),
        .DEPTH (REG_COUNT),
        .ADDR_W(ADDR_W)
    ) u_regfile (
        .clk  (clk),
        .we   (cmd.commit && do_write),
        .waddr(rd_reg[ADDR_W-1:0]),
        .wdata(res_val),
        .raddr(rd_idx[ADDR_W-1:0]),
        .rdata(ram_q)
    );

    // Control and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            hi_reg <= '0;
            lo_reg <= '0;
            count_reg <= '0;
            text_base_reg <= TEXT_BASE_RESET;
            out_valid_reg <= 1'b0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            rd_ok_reg <= ({1'b0, rd_idx} < REG_LIMIT) && written_reg[rd_idx[ADDR_W-1:0]];
            if (cfg_write)
            begin
                text_base_reg <= cfg_data;
            end
            if (cmd.commit)
            begin
                if (do_write)
                begin
                    written_reg[rd_reg[ADDR_W-1:0]] <= 1'b1;
                end
                hi_reg <= hi_next;
                lo_reg <= lo_next;
                count_reg <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= opcode;
            rd_reg <= dest_index;
            ra_reg <= src_a_index;
            rb_reg <= src_b_index;
            imm_reg <= $unsigned(immediate);
        end
        if (cmd.cap_a)
        begin
            va_reg <= rd_data;
        end
        if (cmd.cap_b)
        begin
            vb_reg <= rd_data;
        end
        if (cmd.cap_d)
        begin
            vd_reg <= rd_data;
        end
        if (cmd.start)
        begin
            if (op_reg == OP_MULT)
            begin
                // The mult form takes its second operand from the first source register.
                prod_reg <= vd_reg * va_reg;
            end
            else
            begin
                prod_reg <= va_reg * vb_reg;
            end
            // Divide-by-zero falls out of the restoring loop: every step
            // subtracts zero, giving all ones and the dividend as remainder.
            rem_reg <= '0;
            if (op_reg == OP_DIV2)
            begin
                quo_reg <= vd_reg;
                divisor_reg <= va_reg;
            end
            else
            begin
                quo_reg <= va_reg;
                divisor_reg <= vb_reg;
            end
        end
        if (cmd.div_step)
        begin
            rem_reg <= div_ge ? div_diff[DATA_W-1:0] : div_shift[DATA_W-1:0];
            quo_reg <= {quo_reg[DATA_W-2:0], div_ge};
        end
        if (cmd.commit)
        begin
            out_we_reg <= do_write;
            out_idx_reg <= do_write ? rd_reg : '0;
            out_val_reg <= do_write ? res_val : '0;
            out_hi_reg <= hi_next;
            out_lo_reg <= lo_next;
            out_addr_reg <= addr_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign write_enable = out_we_reg;
    assign write_index = out_idx_reg;
    assign write_value = out_val_reg;
    assign hi_value = out_hi_reg;
    assign lo_value = out_lo_reg;
    assign next_address = out_addr_reg;

    // A commit never overwrites a result that is still held.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> out_free)
        else $error("commit into a stalled output register");

    // A taken result without a new commit empties the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && !cmd.commit) |=> !out_valid_reg)
        else $error("result delivered twice");

    // The counter and HI/LO change only at a commit.
    assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.commit |=> ($stable(count_reg) && $stable(hi_reg) && $stable(lo_reg)))
        else $error("state changed outside a commit");

    // Every commit presents a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("commit produced no result");

endmodule

// ===== rtl/mips_arith_executor_unit.sv =====
// ============================================================================
// Arithmetic executor unit
// Executes one decoded integer instruction per request on a general register
// file with HI/LO and an instruction counter, and reports each result.
// ============================================================================
//
// The request channel (in_valid/in_stall) carries one decoded instruction:
// opcode, dest_index, src_a_index, src_b_index and immediate. The result
// channel (out_valid/out_stall) returns exactly one result per request: the
// register write, HI, LO and the address of the next instruction.
// cfg_write/cfg_data load text_base; write it only while the unit is idle.
//
// One request is in work at a time, and the operand reads share the single
// read port of the register file, one per cycle. A result shows on the
// output after its request has passed the operand reads, the execute step
// and the commit; the two divide forms also pass through the radix-2 divider,
// which yields one quotient bit per cycle. A new request is taken only after
// the previous request has been committed.
//
// rst_n clears the register file (through per-entry written bits), HI, LO
// and the counter, and loads text_base with 0x0040_0000. While out_stall
// holds a result in the output register, the next request is still taken
// and worked on, and waits at its commit step until the result is taken.
//
module mips_arith_executor_unit
    import mae_pkg::*;
#(
    parameter int REG_COUNT = REG_COUNT_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [DATA_W-1:0]        cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [OP_W-1:0]          opcode,
    input  logic [IDX_W-1:0]         dest_index,
    input  logic [IDX_W-1:0]         src_a_index,
    input  logic [IDX_W-1:0]         src_b_index,
    input  logic signed [DATA_W-1:0] immediate,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     write_enable,
    output logic [IDX_W-1:0]         write_index,
    output logic [DATA_W-1:0]        write_value,
    output logic [DATA_W-1:0]        hi_value,
    output logic [DATA_W-1:0]        lo_value,
    output logic [DATA_W-1:0]        next_address
);

    mae_cmd_t    cmd;
    mae_status_t status;

    // The controller sequences reads, execute, divide and commit.
    mae_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .status  (status),
        .cmd     (cmd)
    );

    // The datapath holds all architectural state and the output register.
    mae_datapath #(
        .REG_COUNT(REG_COUNT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .opcode      (opcode),
        .dest_index  (dest_index),
        .src_a_index (src_a_index),
        .src_b_index (src_b_index),
        .immediate   (immediate),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .write_enable(write_enable),
        .write_index (write_index),
        .write_value (write_value),
        .hi_value    (hi_value),
        .lo_value    (lo_value),
        .next_address(next_address)
    );

endmodule
